FILE: rtl/fcfs_mlfq_ready_queue_scheduler_macros.svh
// assertion macros shared by the scheduler checkers
`ifndef FCFS_MLFQ_READY_QUEUE_SCHEDULER_MACROS_SVH
`define FCFS_MLFQ_READY_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled during reset
`define FMQ_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fmq check failed");

// next-cycle implication, disabled during reset
`define FMQ_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fmq check failed");

`endif

FILE: rtl/fmq_pkg.sv
// shared types and codes for the ready-queue scheduler
package fmq_pkg;

  localparam logic [2:0] MODE_PUSH     = 3'd0;
  localparam logic [2:0] MODE_SELECT   = 3'd1;
  localparam logic [2:0] MODE_SETPRIO  = 3'd2;
  localparam logic [2:0] MODE_TO_MLFQ  = 3'd3;
  localparam logic [2:0] MODE_TO_FCFS  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NONE     = 3'd1;
  localparam logic [2:0] ST_BADPRIO  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_INMODE   = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [1:0] TOP_PRIO   = 2'd3;
  localparam logic [1:0] LVL_FCFS   = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  slot;
    logic [15:0] task_pid;
    logic [1:0]  level;
    logic [2:0]  new_priority;
    logic        reset_attrs;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  chosen_slot;
    logic [15:0] chosen_pid;
    logic [1:0]  chosen_level;
  } out_t;

  typedef struct packed {
    logic        lt;
    logic        eq;
    logic [15:0] diff;
  } alu_res_t;

  typedef enum logic [23:0] {
    S_CLEAR     = 24'd1,
    S_IDLE      = 24'd1 << 1,
    S_REDUCE    = 24'd1 << 2,
    S_PUSH_ATTR = 24'd1 << 3,
    S_SEL_RD    = 24'd1 << 4,
    S_SEL_PID   = 24'd1 << 5,
    S_SCAN_A    = 24'd1 << 6,
    S_SCAN_B    = 24'd1 << 7,
    S_SCAN_C    = 24'd1 << 8,
    S_COMP_A    = 24'd1 << 9,
    S_COMP_B    = 24'd1 << 10,
    S_SP_A      = 24'd1 << 11,
    S_SP_B      = 24'd1 << 12,
    S_MV_A      = 24'd1 << 13,
    S_MV_B      = 24'd1 << 14,
    S_GA        = 24'd1 << 15,
    S_GB        = 24'd1 << 16,
    S_GC        = 24'd1 << 17,
    S_SA        = 24'd1 << 18,
    S_SB        = 24'd1 << 19,
    S_SJ_A      = 24'd1 << 20,
    S_SJ_B      = 24'd1 << 21,
    S_EMIT      = 24'd1 << 22,
    S_FINISH    = 24'd1 << 23
  } state_e;

endpackage

FILE: rtl/fmq_ram.sv
// generic single-write, single-read ram with registered read data
module fmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/fmq_alu.sv
// shared compare and subtract unit
module fmq_alu
  import fmq_pkg::*;
(
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output alu_res_t    res_o
);

  logic [16:0] sub;

  assign sub        = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.lt   = sub[16];
  assign res_o.eq   = (a_i == b_i);
  assign res_o.diff = sub[15:0];

endmodule

FILE: rtl/fcfs_mlfq_ready_queue_scheduler.sv
// top level of the fcfs / multilevel feedback ready-queue scheduler
// One transaction in, one result out, one at a time: in_ready_o drops from the accepting edge
// until the result has moved into the output register. After reset the block runs a clearing
// pass over NUM_SLOTS entries of the slot attribute memory before it takes its first
// transaction. Every operation runs on a small sequencer around one shared compare/subtract
// unit and single-write, single-read memories with registered reads, so memory round trips
// set the cost. Each transaction first reduces the slot modulo NUM_SLOTS by repeated
// subtraction (none at 64 slots), then dispatches; errors and unknown modes end there. Push
// then writes the slot attributes, fcfs or level 0/1 select reads the ring entry and then its
// pid, level 2 select scans every queued entry and closes the gap the chosen one leaves, set
// priority searches slot by slot, switch to mlfq moves each fcfs entry into level 0, and switch
// to fcfs gathers every level entry into the sort buffer, exchange-sorts it by pid and appends
// each sorted entry to the fcfs ring. The result then moves into the output register once any
// previous result there has been taken, and out_valid_o rises with it.
module fcfs_mlfq_ready_queue_scheduler
  import fmq_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int IW     = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW     = $clog2(NUM_SLOTS + 1);
  localparam int LAW    = IW + 2;
  localparam int LDEPTH = 3 * (2 ** IW);
  localparam int SBW    = 16 + IW;
  localparam logic [IW-1:0] LAST  = IW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] FULL  = CW'(NUM_SLOTS);
  localparam logic [CW-1:0] LASTC = CW'(NUM_SLOTS - 1);

  // ring pointer step with wrap at NUM_SLOTS
  function automatic logic [IW-1:0] inc_p(input logic [IW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IW-1:0] dec_p(input logic [IW-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  // sequencer and queue bookkeeping
  state_e          state_q, state_d;
  logic            smode_q, smode_d;       // 0 fcfs, 1 mlfq
  logic [IW-1:0]   fhead_q, fhead_d, ftail_q, ftail_d;
  logic [CW-1:0]   fcnt_q, fcnt_d;
  logic [IW-1:0]   lhead_q [3];
  logic [IW-1:0]   lhead_d [3];
  logic [IW-1:0]   ltail_q [3];
  logic [IW-1:0]   ltail_d [3];
  logic [CW-1:0]   lcnt_q  [3];
  logic [CW-1:0]   lcnt_d  [3];

  // working registers of the current transaction
  in_t             item_q, item_d;
  logic [5:0]      red_q, red_d;           // slot being reduced modulo NUM_SLOTS
  out_t            res_q, res_d;
  out_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [CW-1:0]   i_q, i_d, j_q, j_d, n_q, n_d, pos_q, pos_d;
  logic [IW-1:0]   p_q, p_d, pptr_q, pptr_d;
  logic [IW-1:0]   cand_q, cand_d, bslot_q, bslot_d, sel_slot_q, sel_slot_d;
  logic [IW-1:0]   clr_q, clr_d;
  logic [1:0]      best_q, best_d;
  logic            found_q, found_d;
  logic            sel_fcfs_q, sel_fcfs_d;
  logic [SBW-1:0]  bi_q, bi_d;

  // memory ports
  logic            fr_we, lr_we, pid_we, at_we, sb_we;
  logic [IW-1:0]   fr_wa, fr_ra, pid_wa, pid_ra, at_wa, at_ra, sb_wa, sb_ra;
  logic [LAW-1:0]  lr_wa, lr_ra;
  logic [IW-1:0]   fr_wd, fr_rd, lr_wd, lr_rd;
  logic [15:0]     pid_wd, pid_rd;
  logic [2:0]      at_wd, at_rd;           // {valid, priority}
  logic [SBW-1:0]  sb_wd, sb_rd;

  // shared compare unit
  logic [15:0]     alu_a, alu_b;
  alu_res_t        alu;

  logic [IW-1:0]   s_idx;
  logic [1:0]      lvp, lvg;
  logic            better;

  assign s_idx = IW'(red_q);
  // a fresh task lands on level 0, level three saturates to level 2
  assign lvp   = item_q.reset_attrs ? 2'd0 : ((item_q.level == 2'd3) ? 2'd2 : item_q.level);
  assign lvg   = (lcnt_q[0] != '0) ? 2'd0 : ((lcnt_q[1] != '0) ? 2'd1 : 2'd2);
  assign better = !found_q || alu.lt;

  fmq_ram #(.WIDTH(IW), .DEPTH(2 ** IW)) u_fcfs_ring (
    .clk_i, .we_i(fr_we), .waddr_i(fr_wa), .wdata_i(fr_wd), .raddr_i(fr_ra), .rdata_o(fr_rd)
  );

  // three level rings share one memory, addressed by {level, index}
  fmq_ram #(.WIDTH(IW), .DEPTH(LDEPTH)) u_level_rings (
    .clk_i, .we_i(lr_we), .waddr_i(lr_wa), .wdata_i(lr_wd), .raddr_i(lr_ra), .rdata_o(lr_rd)
  );

  fmq_ram #(.WIDTH(16), .DEPTH(2 ** IW)) u_slot_pid (
    .clk_i, .we_i(pid_we), .waddr_i(pid_wa), .wdata_i(pid_wd), .raddr_i(pid_ra),
    .rdata_o(pid_rd)
  );

  fmq_ram #(.WIDTH(3), .DEPTH(2 ** IW)) u_slot_attr (
    .clk_i, .we_i(at_we), .waddr_i(at_wa), .wdata_i(at_wd), .raddr_i(at_ra), .rdata_o(at_rd)
  );

  // sort buffer entries carry {pid, slot} so compares need no extra pid lookup
  fmq_ram #(.WIDTH(SBW), .DEPTH(2 ** IW)) u_sort_buf (
    .clk_i, .we_i(sb_we), .waddr_i(sb_wa), .wdata_i(sb_wd), .raddr_i(sb_ra), .rdata_o(sb_rd)
  );

  fmq_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .res_o(alu)
  );

  // compare operands follow the sequencer state
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      S_REDUCE: begin
        alu_a = {10'd0, red_q};
        alu_b = 16'(NUM_SLOTS);
      end
      S_SCAN_C: begin
        alu_a = {14'd0, best_q};
        alu_b = {14'd0, at_rd[1:0]};
      end
      S_SP_B: begin
        alu_a = pid_rd;
        alu_b = item_q.task_pid;
      end
      S_SJ_B: begin
        alu_a = sb_rd[SBW-1 -: 16];
        alu_b = bi_q[SBW-1 -: 16];
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    smode_d     = smode_q;
    fhead_d     = fhead_q;
    ftail_d     = ftail_q;
    fcnt_d      = fcnt_q;
    lhead_d     = lhead_q;
    ltail_d     = ltail_q;
    lcnt_d      = lcnt_q;
    item_d      = item_q;
    red_d       = red_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    pos_d       = pos_q;
    p_d         = p_q;
    pptr_d      = pptr_q;
    cand_d      = cand_q;
    bslot_d     = bslot_q;
    sel_slot_d  = sel_slot_q;
    clr_d       = clr_q;
    best_d      = best_q;
    found_d     = found_q;
    sel_fcfs_d  = sel_fcfs_q;
    bi_d        = bi_q;

    fr_we  = 1'b0;  fr_wa  = '0;  fr_wd  = '0;  fr_ra  = '0;
    lr_we  = 1'b0;  lr_wa  = '0;  lr_wd  = '0;  lr_ra  = '0;
    pid_we = 1'b0;  pid_wa = '0;  pid_wd = '0;  pid_ra = '0;
    at_we  = 1'b0;  at_wa  = '0;  at_wd  = '0;  at_ra  = '0;
    sb_we  = 1'b0;  sb_wa  = '0;  sb_wd  = '0;  sb_ra  = '0;

    case (state_q)
      // all slots start invalid with top priority
      S_CLEAR: begin
        at_we = 1'b1;
        at_wa = clr_q;
        at_wd = {1'b0, TOP_PRIO};
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          red_d   = in_data_i.slot;
          res_d   = '0;
          state_d = S_REDUCE;
        end
      end

      // subtract NUM_SLOTS until the slot is in range, then dispatch
      S_REDUCE: begin
        if (!alu.lt) begin
          red_d = alu.diff[5:0];
        end else begin
          case (item_q.mode)
            MODE_PUSH: begin
              if (!smode_q && fcnt_q == FULL) begin
                res_d.status = ST_FULL;
                state_d      = S_FINISH;
              end else if (smode_q && lcnt_q[lvp] == FULL) begin
                res_d.status = ST_FULL;
                state_d      = S_FINISH;
              end else begin
                if (!smode_q) begin
                  fr_we   = 1'b1;
                  fr_wa   = ftail_q;
                  fr_wd   = s_idx;
                  ftail_d = inc_p(ftail_q);
                  fcnt_d  = fcnt_q + 1'b1;
                end else begin
                  lr_we        = 1'b1;
                  lr_wa        = {lvp, ltail_q[lvp]};
                  lr_wd        = s_idx;
                  ltail_d[lvp] = inc_p(ltail_q[lvp]);
                  lcnt_d[lvp]  = lcnt_q[lvp] + 1'b1;
                end
                pid_we  = 1'b1;
                pid_wa  = s_idx;
                pid_wd  = item_q.task_pid;
                at_ra   = s_idx;
                state_d = S_PUSH_ATTR;
              end
            end
            MODE_SELECT: begin
              if (!smode_q) begin
                if (fcnt_q == '0) begin
                  res_d.status = ST_NONE;
                  state_d      = S_FINISH;
                end else begin
                  fr_ra              = fhead_q;
                  fhead_d            = inc_p(fhead_q);
                  fcnt_d             = fcnt_q - 1'b1;
                  sel_fcfs_d         = 1'b1;
                  res_d.chosen_level = LVL_FCFS;
                  state_d            = S_SEL_RD;
                end
              end else if (lcnt_q[0] != '0 || lcnt_q[1] != '0) begin
                lr_ra              = {lvg, lhead_q[lvg]};
                lhead_d[lvg]       = inc_p(lhead_q[lvg]);
                lcnt_d[lvg]        = lcnt_q[lvg] - 1'b1;
                sel_fcfs_d         = 1'b0;
                res_d.chosen_level = lvg;
                state_d            = S_SEL_RD;
              end else if (lcnt_q[2] == '0) begin
                res_d.status = ST_NONE;
                state_d      = S_FINISH;
              end else begin
                p_d     = lhead_q[2];
                i_d     = '0;
                pos_d   = '0;
                found_d = 1'b0;
                best_d  = '0;
                state_d = S_SCAN_A;
              end
            end
            MODE_SETPRIO: begin
              if (item_q.new_priority[2]) begin
                res_d.status = ST_BADPRIO;
                state_d      = S_FINISH;
              end else begin
                i_d     = '0;
                state_d = S_SP_A;
              end
            end
            MODE_TO_MLFQ: begin
              if (smode_q) begin
                res_d.status = ST_INMODE;
                state_d      = S_FINISH;
              end else begin
                smode_d = 1'b1;
                lhead_d = '{default: '0};
                ltail_d = '{default: '0};
                lcnt_d  = '{default: '0};
                state_d = S_MV_A;
              end
            end
            MODE_TO_FCFS: begin
              if (!smode_q) begin
                res_d.status = ST_INMODE;
                state_d      = S_FINISH;
              end else begin
                smode_d = 1'b0;
                n_d     = '0;
                state_d = S_GA;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      // a fresh push restores top priority, otherwise priority is kept
      S_PUSH_ATTR: begin
        at_we   = 1'b1;
        at_wa   = s_idx;
        at_wd   = {1'b1, item_q.reset_attrs ? TOP_PRIO : at_rd[1:0]};
        state_d = S_FINISH;
      end

      S_SEL_RD: begin
        sel_slot_d = sel_fcfs_q ? fr_rd : lr_rd;
        pid_ra     = sel_fcfs_q ? fr_rd : lr_rd;
        state_d    = S_SEL_PID;
      end

      S_SEL_PID: begin
        res_d.status      = ST_OK;
        res_d.chosen_slot = 6'(sel_slot_q);
        res_d.chosen_pid  = pid_rd;
        state_d           = S_FINISH;
      end

      // level 2 scan: ring entry, then its priority, then compare
      S_SCAN_A: begin
        lr_ra   = {2'd2, p_q};
        state_d = S_SCAN_B;
      end

      S_SCAN_B: begin
        at_ra   = lr_rd;
        cand_d  = lr_rd;
        state_d = S_SCAN_C;
      end

      S_SCAN_C: begin
        // strict greater keeps the entry nearest the head on ties
        if (better) begin
          found_d = 1'b1;
          best_d  = at_rd[1:0];
          bslot_d = cand_q;
          pos_d   = i_q;
          pptr_d  = p_q;
        end
        if (i_q + 1'b1 == lcnt_q[2]) begin
          p_d     = better ? p_q : pptr_q;
          state_d = S_COMP_A;
        end else begin
          p_d     = inc_p(p_q);
          i_d     = i_q + 1'b1;
          state_d = S_SCAN_A;
        end
      end

      // close the gap: shift later entries one place toward the head
      S_COMP_A: begin
        if (pos_q + 1'b1 < lcnt_q[2]) begin
          lr_ra   = {2'd2, inc_p(p_q)};
          state_d = S_COMP_B;
        end else begin
          ltail_d[2]         = dec_p(ltail_q[2]);
          lcnt_d[2]          = lcnt_q[2] - 1'b1;
          sel_slot_d         = bslot_q;
          pid_ra             = bslot_q;
          res_d.chosen_level = 2'd2;
          state_d            = S_SEL_PID;
        end
      end

      S_COMP_B: begin
        lr_we   = 1'b1;
        lr_wa   = {2'd2, p_q};
        lr_wd   = lr_rd;
        p_d     = inc_p(p_q);
        pos_d   = pos_q + 1'b1;
        state_d = S_COMP_A;
      end

      // set priority: lowest valid slot with a matching pid
      S_SP_A: begin
        at_ra   = i_q[IW-1:0];
        pid_ra  = i_q[IW-1:0];
        state_d = S_SP_B;
      end

      S_SP_B: begin
        if (at_rd[2] && alu.eq) begin
          at_we   = 1'b1;
          at_wa   = i_q[IW-1:0];
          at_wd   = {1'b1, item_q.new_priority[1:0]};
          state_d = S_FINISH;
        end else if (i_q == LASTC) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_FINISH;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SP_A;
        end
      end

      // switch to mlfq: drain fcfs ring into level 0 at top priority
      S_MV_A: begin
        if (fcnt_q == '0) begin
          fhead_d = '0;
          ftail_d = '0;
          state_d = S_FINISH;
        end else begin
          fr_ra   = fhead_q;
          fhead_d = inc_p(fhead_q);
          fcnt_d  = fcnt_q - 1'b1;
          state_d = S_MV_B;
        end
      end

      S_MV_B: begin
        at_we      = 1'b1;
        at_wa      = fr_rd;
        at_wd      = {1'b1, TOP_PRIO};
        lr_we      = 1'b1;
        lr_wa      = {2'd0, ltail_q[0]};
        lr_wd      = fr_rd;
        ltail_d[0] = inc_p(ltail_q[0]);
        lcnt_d[0]  = lcnt_q[0] + 1'b1;
        state_d    = S_MV_A;
      end

      // switch to fcfs: gather levels 0..2 into the sort buffer
      S_GA: begin
        if (lcnt_q[0] == '0 && lcnt_q[1] == '0 && lcnt_q[2] == '0) begin
          lhead_d = '{default: '0};
          ltail_d = '{default: '0};
          fhead_d = '0;
          ftail_d = '0;
          fcnt_d  = '0;
          i_d     = '0;
          state_d = (n_q == '0) ? S_FINISH : S_SA;
        end else begin
          lr_ra        = {lvg, lhead_q[lvg]};
          lhead_d[lvg] = inc_p(lhead_q[lvg]);
          lcnt_d[lvg]  = lcnt_q[lvg] - 1'b1;
          state_d      = S_GB;
        end
      end

      S_GB: begin
        pid_ra  = lr_rd;
        cand_d  = lr_rd;
        state_d = S_GC;
      end

      S_GC: begin
        // entries past NUM_SLOTS are dropped
        if (n_q != FULL) begin
          sb_we = 1'b1;
          sb_wa = n_q[IW-1:0];
          sb_wd = {pid_rd, cand_q};
          n_d   = n_q + 1'b1;
        end
        state_d = S_GA;
      end

      // exchange sort: position i holds its running minimum in bi
      S_SA: begin
        sb_ra   = i_q[IW-1:0];
        state_d = S_SB;
      end

      S_SB: begin
        bi_d    = sb_rd;
        j_d     = i_q + 1'b1;
        state_d = (i_q + 1'b1 < n_q) ? S_SJ_A : S_EMIT;
      end

      S_SJ_A: begin
        sb_ra   = j_q[IW-1:0];
        state_d = S_SJ_B;
      end

      S_SJ_B: begin
        if (alu.lt) begin
          sb_we = 1'b1;
          sb_wa = j_q[IW-1:0];
          sb_wd = bi_q;
          bi_d  = sb_rd;
        end
        j_d     = j_q + 1'b1;
        state_d = (j_q + 1'b1 < n_q) ? S_SJ_A : S_EMIT;
      end

      // position i is final, append it to the fcfs ring
      S_EMIT: begin
        fr_we   = 1'b1;
        fr_wa   = ftail_q;
        fr_wd   = bi_q[IW-1:0];
        ftail_d = inc_p(ftail_q);
        fcnt_d  = fcnt_q + 1'b1;
        i_d     = i_q + 1'b1;
        state_d = (i_q + 1'b1 < n_q) ? S_SA : S_FINISH;
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      smode_q     <= 1'b0;
      fhead_q     <= '0;
      ftail_q     <= '0;
      fcnt_q      <= '0;
      lhead_q     <= '{default: '0};
      ltail_q     <= '{default: '0};
      lcnt_q      <= '{default: '0};
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      smode_q     <= smode_d;
      fhead_q     <= fhead_d;
      ftail_q     <= ftail_d;
      fcnt_q      <= fcnt_d;
      lhead_q     <= lhead_d;
      ltail_q     <= ltail_d;
      lcnt_q      <= lcnt_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    red_q      <= red_d;
    res_q      <= res_d;
    out_q      <= out_d;
    i_q        <= i_d;
    j_q        <= j_d;
    n_q        <= n_d;
    pos_q      <= pos_d;
    p_q        <= p_d;
    pptr_q     <= pptr_d;
    cand_q     <= cand_d;
    bslot_q    <= bslot_d;
    sel_slot_q <= sel_slot_d;
    best_q     <= best_d;
    found_q    <= found_d;
    sel_fcfs_q <= sel_fcfs_d;
    bi_q       <= bi_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/fmq_checker.sv
// port-level checker for the scheduler, bound to the top level
`include "fcfs_mlfq_ready_queue_scheduler_macros.svh"

module fmq_checker
  import fmq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // a pending result holds until taken
  `FMQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))

  // chosen fields are zero on every result whose status is not ok
  `FMQ_ASSERT_NOW(a_chosen_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_OK,
    out_data_o.chosen_slot == '0 && out_data_o.chosen_pid == '0 &&
    out_data_o.chosen_level == '0)

  // one transaction at a time: no accept right after an accept
  `FMQ_ASSERT_NEXT(a_one_at_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // status is always a defined code
  `FMQ_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o,
    out_data_o.status == ST_OK || out_data_o.status == ST_NONE ||
    out_data_o.status == ST_BADPRIO || out_data_o.status == ST_NOTFOUND ||
    out_data_o.status == ST_INMODE || out_data_o.status == ST_FULL)

endmodule

bind fcfs_mlfq_ready_queue_scheduler fmq_checker u_fmq_checker (.*);
